[design/occ_pkg.sv]
// ---------------------------------------------------------------------------
// occ_pkg: shared types and constants for box-box contact clipping
// Payload structs, the per-pair context that travels through the clip
// stages, fixed-point constants and the 32-bit saturation helper.
// ---------------------------------------------------------------------------
`default_nettype none

package occ_pkg;

    // fraction bits of cos/sin/normal and of the clip parameter
    localparam int DIR_FRAC    = 14;
    localparam int T_FRAC      = 16;
    // one quotient bit per divider stage, quotient spans 0 .. 2^T_FRAC
    localparam int DIV_STEPS   = T_FRAC + 1;
    // depth tolerance in units of 2^-30
    localparam int CONTACT_TOL = 10737;

    typedef struct packed {
        logic signed [31:0] a_center_x;
        logic signed [31:0] a_center_y;
        logic signed [15:0] a_cos;
        logic signed [15:0] a_sin;
        logic        [30:0] a_half_width;
        logic        [30:0] a_half_height;
        logic signed [31:0] b_center_x;
        logic signed [31:0] b_center_y;
        logic signed [15:0] b_cos;
        logic signed [15:0] b_sin;
        logic        [30:0] b_half_width;
        logic        [30:0] b_half_height;
    } t_in;

    typedef struct packed {
        logic        [1:0]  contact_count;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic        [30:0] penetration;
        logic signed [31:0] point0_x;
        logic signed [31:0] point0_y;
        logic signed [31:0] point1_x;
        logic signed [31:0] point1_y;
    } t_out;

    // per-pair state carried through the clipping stages
    typedef struct packed {
        logic               dead;
        logic signed [16:0] nx;
        logic signed [16:0] ny;
        logic        [38:0] depth;
        logic signed [16:0] rfx;
        logic signed [16:0] rfy;
        logic signed [31:0] fcx;
        logic signed [31:0] fcy;
        logic signed [31:0] rsx;
        logic signed [31:0] rsy;
        logic signed [31:0] rex;
        logic signed [31:0] rey;
        logic signed [16:0] sdx;
        logic signed [16:0] sdy;
        logic signed [31:0] c0x;
        logic signed [31:0] c0y;
        logic signed [31:0] c1x;
        logic signed [31:0] c1y;
    } t_ctx;

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -40'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[design/occ_clip.sv]
// ---------------------------------------------------------------------------
// occ_clip: pipelined clip of the incident segment against one side plane
// Side distances, then a restoring divider one quotient bit per stage for
// t = d1 / (d1 - d2), then the intersection point replaces the outside end.
// ---------------------------------------------------------------------------
`default_nettype none

module occ_clip (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_vld,
    input  wire occ_pkg::t_ctx      i_ctx,
    input  wire logic signed [31:0] i_ppx,
    input  wire logic signed [31:0] i_ppy,
    input  wire logic signed [16:0] i_pnx,
    input  wire logic signed [16:0] i_pny,
    output logic                    o_vld,
    output occ_pkg::t_ctx           o_ctx
);

    localparam int NSTEP = occ_pkg::DIV_STEPS;

    localparam logic [1:0] MODE_KEEP   = 2'd0;
    localparam logic [1:0] MODE_CUT_P2 = 2'd1;
    localparam logic [1:0] MODE_CUT_P1 = 2'd2;

    // stage a: distance products
    logic                r_a_vld;
    occ_pkg::t_ctx       r_a_ctx;
    logic signed [49:0]  r_a_m0x, r_a_m0y, r_a_m1x, r_a_m1y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_ctx <= i_ctx;
            r_a_m0x <= 50'(33'(i_ctx.c0x) - 33'(i_ppx)) * 50'(i_pnx);
            r_a_m0y <= 50'(33'(i_ctx.c0y) - 33'(i_ppy)) * 50'(i_pny);
            r_a_m1x <= 50'(33'(i_ctx.c1x) - 33'(i_ppx)) * 50'(i_pnx);
            r_a_m1y <= 50'(33'(i_ctx.c1y) - 33'(i_ppy)) * 50'(i_pny);
        end
    end

    // stage b: distances, crossing mode, divider operands
    logic signed [50:0] w_s1, w_s2;
    logic signed [36:0] w_d1, w_d2;
    logic        [36:0] w_a1, w_a2;
    logic        [1:0]  n_mode;
    occ_pkg::t_ctx      n_ctx;

    always_comb begin
        w_s1   = 51'(r_a_m0x) + 51'(r_a_m0y);
        w_s2   = 51'(r_a_m1x) + 51'(r_a_m1y);
        w_d1   = 37'(w_s1 >>> occ_pkg::DIR_FRAC);
        w_d2   = 37'(w_s2 >>> occ_pkg::DIR_FRAC);
        w_a1   = w_d1[36] ? 37'(-w_d1) : 37'(w_d1);
        w_a2   = w_d2[36] ? 37'(-w_d2) : 37'(w_d2);
        n_ctx  = r_a_ctx;
        n_mode = MODE_KEEP;
        if (w_d1[36] && w_d2[36]) begin
            n_ctx.dead = 1'b1;
        end else if (!w_d1[36] && w_d2[36]) begin
            n_mode = MODE_CUT_P2;
        end else if (w_d1[36] && !w_d2[36]) begin
            n_mode = MODE_CUT_P1;
        end
    end

    // divider pipeline, entry 0 is the stage b register
    logic                r_dv_vld  [0:NSTEP];
    logic [occ_pkg::T_FRAC:0] r_dv_q [0:NSTEP];
    logic [1:0]          r_dv_mode [0:NSTEP];
    occ_pkg::t_ctx       r_dv_ctx  [0:NSTEP];
    logic [53:0]         r_dv_r    [0:NSTEP-1];
    logic [37:0]         r_dv_d    [0:NSTEP-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_dv_vld[0] <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv_q[0]    <= '0;
            r_dv_mode[0] <= n_mode;
            r_dv_ctx[0]  <= n_ctx;
            r_dv_r[0]    <= 54'(w_a1) << occ_pkg::T_FRAC;
            r_dv_d[0]    <= 38'(w_a1) + 38'(w_a2);
        end
    end

    for (genvar j = 0; j < NSTEP; j++) begin : g_div
        localparam int K = NSTEP - 1 - j;
        logic [54:0] w_trial;

        // trial subtract of the shifted divisor
        assign w_trial = {1'b0, r_dv_r[j]} - (55'(r_dv_d[j]) << K);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[j+1] <= 1'b0;
            end else if (i_en) begin
                r_dv_vld[j+1] <= r_dv_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv_mode[j+1] <= r_dv_mode[j];
                r_dv_ctx[j+1]  <= r_dv_ctx[j];
                if (!w_trial[54]) begin
                    r_dv_q[j+1] <= r_dv_q[j] | ((occ_pkg::T_FRAC+1)'(1) << K);
                end else begin
                    r_dv_q[j+1] <= r_dv_q[j];
                end
            end
        end

        if (j < NSTEP - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_dv_d[j+1] <= r_dv_d[j];
                    r_dv_r[j+1] <= w_trial[54] ? r_dv_r[j] : w_trial[53:0];
                end
            end
        end
    end

    // stage c: direction times t
    logic               r_c_vld;
    logic [1:0]         r_c_mode;
    occ_pkg::t_ctx      r_c_ctx;
    logic signed [50:0] r_c_px, r_c_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_c_vld <= r_dv_vld[NSTEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_mode <= r_dv_mode[NSTEP];
            r_c_ctx  <= r_dv_ctx[NSTEP];
            r_c_px   <= 51'(33'(r_dv_ctx[NSTEP].c1x) - 33'(r_dv_ctx[NSTEP].c0x))
                        * 51'($signed({1'b0, r_dv_q[NSTEP]}));
            r_c_py   <= 51'(33'(r_dv_ctx[NSTEP].c1y) - 33'(r_dv_ctx[NSTEP].c0y))
                        * 51'($signed({1'b0, r_dv_q[NSTEP]}));
        end
    end

    // stage d: intersection replaces the end point outside the plane
    logic signed [31:0] w_hx, w_hy;
    occ_pkg::t_ctx      n_d_ctx;

    always_comb begin
        w_hx    = occ_pkg::sat32(40'(r_c_ctx.c0x) + 40'(r_c_px >>> occ_pkg::T_FRAC));
        w_hy    = occ_pkg::sat32(40'(r_c_ctx.c0y) + 40'(r_c_py >>> occ_pkg::T_FRAC));
        n_d_ctx = r_c_ctx;
        case (r_c_mode)
            MODE_CUT_P2: begin
                n_d_ctx.c1x = w_hx;
                n_d_ctx.c1y = w_hy;
            end
            MODE_CUT_P1: begin
                n_d_ctx.c0x = w_hx;
                n_d_ctx.c0y = w_hy;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ctx <= n_d_ctx;
        end
    end

endmodule

`default_nettype wire

[design/obb_obb_contact_clipping_unit.sv]
// One pair per cycle sustained while no result is stalled at the output.
// The two clip divisions are 17-stage restoring dividers, one quotient bit a stage.
// A stalled output freezes the whole pipeline; input ready follows output space.
// Reset (synchronous, active low) clears all stage valid bits; data is not reset.
// ---------------------------------------------------------------------------
// obb_obb_contact_clipping_unit: 2D oriented box pair contact generator
// Separating-axis test over four axes, reference/incident face selection,
// two side-plane clips and a depth test, as one deep pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

module obb_obb_contact_clipping_unit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire occ_pkg::t_in   i_in_data,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output occ_pkg::t_out       o_out_data
);

    localparam int DF = occ_pkg::DIR_FRAC;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [16:0] rx;
        logic signed [16:0] ry;
        logic signed [16:0] ux;
        logic signed [16:0] uy;
        logic        [30:0] hw;
        logic        [30:0] hh;
    } t_box;

    // axis decoders: A right, A up, B right, B up
    function automatic logic signed [16:0] ax_x(input occ_pkg::t_in v, input logic [1:0] i);
        logic signed [16:0] r;
        unique case (i)
            2'd0:    r = 17'(v.a_cos);
            2'd1:    r = -17'(v.a_sin);
            2'd2:    r = 17'(v.b_cos);
            default: r = -17'(v.b_sin);
        endcase
        return r;
    endfunction

    function automatic logic signed [16:0] ax_y(input occ_pkg::t_in v, input logic [1:0] i);
        logic signed [16:0] r;
        unique case (i)
            2'd0:    r = 17'(v.a_sin);
            2'd1:    r = 17'(v.a_cos);
            2'd2:    r = 17'(v.b_sin);
            default: r = 17'(v.b_cos);
        endcase
        return r;
    endfunction

    function automatic t_box box_of(input occ_pkg::t_in v, input logic b);
        t_box r;
        r.px = b ? v.b_center_x : v.a_center_x;
        r.py = b ? v.b_center_y : v.a_center_y;
        r.rx = ax_x(v, {b, 1'b0});
        r.ry = ax_y(v, {b, 1'b0});
        r.ux = ax_x(v, {b, 1'b1});
        r.uy = ax_y(v, {b, 1'b1});
        r.hw = b ? v.b_half_width : v.a_half_width;
        r.hh = b ? v.b_half_height : v.a_half_height;
        return r;
    endfunction

    logic en;
    logic r_vld [1:10];
    logic r_f1_vld;
    logic r_out_vld;

    // whole pipeline advances unless a result waits at the output
    assign en          = !r_out_vld || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_out_vld;

    // stage valid bits
    logic w_c1_vld, w_c2_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 1; i <= 10; i++) begin
                r_vld[i] <= 1'b0;
            end
            r_f1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_vld[1] <= i_in_valid;
            for (int i = 2; i <= 10; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
            r_f1_vld  <= w_c2_vld;
            r_out_vld <= r_f1_vld;
        end
    end

    // stage 1: rotation products and center delta
    occ_pkg::t_in       r1_in;
    logic signed [31:0] r1_cc, r1_ss, r1_cs, r1_sc;
    logic signed [32:0] r1_dx, r1_dy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_in <= i_in_data;
            r1_cc <= 32'(i_in_data.a_cos) * 32'(i_in_data.b_cos);
            r1_ss <= 32'(i_in_data.a_sin) * 32'(i_in_data.b_sin);
            r1_cs <= 32'(i_in_data.a_cos) * 32'(i_in_data.b_sin);
            r1_sc <= 32'(i_in_data.a_sin) * 32'(i_in_data.b_cos);
            r1_dx <= 33'(i_in_data.b_center_x) - 33'(i_in_data.a_center_x);
            r1_dy <= 33'(i_in_data.b_center_y) - 33'(i_in_data.a_center_y);
        end
    end

    // stage 2: relative rotation terms and projection products
    logic signed [18:0] w2_rc, w2_rs;
    occ_pkg::t_in       r2_in;
    logic        [17:0] r2_rc, r2_rs;
    logic signed [49:0] r2_pxx [4];
    logic signed [49:0] r2_pxy [4];

    always_comb begin
        w2_rc = 19'((33'(r1_cc) + 33'(r1_ss)) >>> DF);
        w2_rs = 19'((33'(r1_cs) - 33'(r1_sc)) >>> DF);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_in <= r1_in;
            r2_rc <= w2_rc[18] ? 18'(-w2_rc) : 18'(w2_rc);
            r2_rs <= w2_rs[18] ? 18'(-w2_rs) : 18'(w2_rs);
            for (int i = 0; i < 4; i++) begin
                r2_pxx[i] <= 50'(r1_dx) * 50'(ax_x(r1_in, 2'(i)));
                r2_pxy[i] <= 50'(r1_dy) * 50'(ax_y(r1_in, 2'(i)));
            end
        end
    end

    // stage 3: projections and extent products
    occ_pkg::t_in       r3_in;
    logic signed [36:0] r3_proj [4];
    logic        [48:0] r3_m    [8];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_in <= r2_in;
            for (int i = 0; i < 4; i++) begin
                r3_proj[i] <= 37'((51'(r2_pxx[i]) + 51'(r2_pxy[i])) >>> DF);
            end
            r3_m[0] <= 49'(r2_in.b_half_width)  * 49'(r2_rc);
            r3_m[1] <= 49'(r2_in.b_half_height) * 49'(r2_rs);
            r3_m[2] <= 49'(r2_in.b_half_width)  * 49'(r2_rs);
            r3_m[3] <= 49'(r2_in.b_half_height) * 49'(r2_rc);
            r3_m[4] <= 49'(r2_in.a_half_width)  * 49'(r2_rc);
            r3_m[5] <= 49'(r2_in.a_half_height) * 49'(r2_rs);
            r3_m[6] <= 49'(r2_in.a_half_width)  * 49'(r2_rs);
            r3_m[7] <= 49'(r2_in.a_half_height) * 49'(r2_rc);
        end
    end

    // stage 4: overlap per axis
    logic        [36:0] w4_sum [4];
    logic        [36:0] w4_ap  [4];
    logic        [30:0] w4_h   [4];
    occ_pkg::t_in       r4_in;
    logic signed [38:0] r4_ov   [4];
    logic               r4_pneg [4];

    always_comb begin
        w4_h[0] = r3_in.a_half_width;
        w4_h[1] = r3_in.a_half_height;
        w4_h[2] = r3_in.b_half_width;
        w4_h[3] = r3_in.b_half_height;
        for (int i = 0; i < 4; i++) begin
            w4_sum[i] = 37'(r3_m[2*i] >> DF) + 37'(r3_m[2*i+1] >> DF) + 37'(w4_h[i]);
            w4_ap[i]  = r3_proj[i][36] ? 37'(-r3_proj[i]) : 37'(r3_proj[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_in <= r3_in;
            for (int i = 0; i < 4; i++) begin
                r4_ov[i]   <= $signed({2'b00, w4_sum[i]}) - $signed({2'b00, w4_ap[i]});
                r4_pneg[i] <= r3_proj[i][36];
            end
        end
    end

    // stage 5: least overlap, earlier axis wins ties
    logic signed [38:0] w5_dep;
    logic        [1:0]  w5_best;
    logic               w5_sep;
    logic signed [16:0] w5_axx, w5_axy;
    occ_pkg::t_in       r5_in;
    logic               r5_dead, r5_swap;
    logic        [38:0] r5_depth;
    logic signed [16:0] r5_nx, r5_ny;

    always_comb begin
        w5_dep  = r4_ov[0];
        w5_best = 2'd0;
        w5_sep  = 1'b0;
        for (int i = 0; i < 4; i++) begin
            if (r4_ov[i] < 0) begin
                w5_sep = 1'b1;
            end
            if (r4_ov[i] < w5_dep) begin
                w5_dep  = r4_ov[i];
                w5_best = 2'(i);
            end
        end
        w5_axx = ax_x(r4_in, w5_best);
        w5_axy = ax_y(r4_in, w5_best);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r5_in    <= r4_in;
            r5_dead  <= w5_sep;
            r5_swap  <= w5_best[1];
            r5_depth <= w5_dep;
            r5_nx    <= r4_pneg[w5_best] ? -w5_axx : w5_axx;
            r5_ny    <= r4_pneg[w5_best] ? -w5_axy : w5_axy;
        end
    end

    // stage 6: reference normal and face alignment dots
    t_box               w6_rb, w6_ib;
    logic signed [16:0] w6_rfx, w6_rfy;
    occ_pkg::t_in       r6_in;
    logic               r6_dead, r6_swap;
    logic        [38:0] r6_depth;
    logic signed [16:0] r6_nx, r6_ny, r6_rfx, r6_rfy;
    logic signed [34:0] r6_drx, r6_dry, r6_dix, r6_diy;

    always_comb begin
        w6_rb  = box_of(r5_in, r5_swap);
        w6_ib  = box_of(r5_in, !r5_swap);
        w6_rfx = r5_swap ? -r5_nx : r5_nx;
        w6_rfy = r5_swap ? -r5_ny : r5_ny;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_in    <= r5_in;
            r6_dead  <= r5_dead;
            r6_swap  <= r5_swap;
            r6_depth <= r5_depth;
            r6_nx    <= r5_nx;
            r6_ny    <= r5_ny;
            r6_rfx   <= w6_rfx;
            r6_rfy   <= w6_rfy;
            r6_drx   <= 35'(w6_rfx) * 35'(w6_rb.rx) + 35'(w6_rfy) * 35'(w6_rb.ry);
            r6_dry   <= 35'(w6_rfx) * 35'(w6_rb.ux) + 35'(w6_rfy) * 35'(w6_rb.uy);
            r6_dix   <= 35'(w6_rfx) * 35'(w6_ib.rx) + 35'(w6_rfy) * 35'(w6_ib.ry);
            r6_diy   <= 35'(w6_rfx) * 35'(w6_ib.ux) + 35'(w6_rfy) * 35'(w6_ib.uy);
        end
    end

    // stage 7: face pick for reference (toward normal) and incident (away)
    t_box               w7_rb, w7_ib;
    logic        [34:0] w7_adrx, w7_adry, w7_adix, w7_adiy;
    logic               w7_rx_sel, w7_ix_sel, w7_rneg, w7_ineg;
    logic signed [31:0] w7_rh, w7_ih;
    logic signed [31:0] r7_rpx, r7_rpy, r7_ipx, r7_ipy, r7_rlen, r7_ilen;
    logic signed [16:0] r7_rdx, r7_rdy, r7_idx, r7_idy;
    logic signed [16:0] r7_rsx, r7_rsy, r7_isx, r7_isy;
    logic        [30:0] r7_rsl, r7_isl;
    logic               r7_dead;
    logic        [38:0] r7_depth;
    logic signed [16:0] r7_nx, r7_ny, r7_rfx, r7_rfy;

    always_comb begin
        w7_rb     = box_of(r6_in, r6_swap);
        w7_ib     = box_of(r6_in, !r6_swap);
        w7_adrx   = r6_drx[34] ? 35'(-r6_drx) : 35'(r6_drx);
        w7_adry   = r6_dry[34] ? 35'(-r6_dry) : 35'(r6_dry);
        w7_adix   = r6_dix[34] ? 35'(-r6_dix) : 35'(r6_dix);
        w7_adiy   = r6_diy[34] ? 35'(-r6_diy) : 35'(r6_diy);
        w7_rx_sel = w7_adrx > w7_adry;
        w7_ix_sel = w7_adix > w7_adiy;
        w7_rneg   = w7_rx_sel ? r6_drx[34] : r6_dry[34];
        w7_ineg   = !(w7_ix_sel ? r6_dix[34] : r6_diy[34]);
        w7_rh     = $signed({1'b0, (w7_rx_sel ? w7_rb.hw : w7_rb.hh)});
        w7_ih     = $signed({1'b0, (w7_ix_sel ? w7_ib.hw : w7_ib.hh)});
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_rpx   <= w7_rb.px;
            r7_rpy   <= w7_rb.py;
            r7_ipx   <= w7_ib.px;
            r7_ipy   <= w7_ib.py;
            r7_rlen  <= w7_rneg ? -w7_rh : w7_rh;
            r7_ilen  <= w7_ineg ? -w7_ih : w7_ih;
            r7_rdx   <= w7_rx_sel ? w7_rb.rx : w7_rb.ux;
            r7_rdy   <= w7_rx_sel ? w7_rb.ry : w7_rb.uy;
            r7_idx   <= w7_ix_sel ? w7_ib.rx : w7_ib.ux;
            r7_idy   <= w7_ix_sel ? w7_ib.ry : w7_ib.uy;
            r7_rsx   <= w7_rx_sel ? w7_rb.ux : w7_rb.rx;
            r7_rsy   <= w7_rx_sel ? w7_rb.uy : w7_rb.ry;
            r7_isx   <= w7_ix_sel ? w7_ib.ux : w7_ib.rx;
            r7_isy   <= w7_ix_sel ? w7_ib.uy : w7_ib.ry;
            r7_rsl   <= w7_rx_sel ? w7_rb.hh : w7_rb.hw;
            r7_isl   <= w7_ix_sel ? w7_ib.hh : w7_ib.hw;
            r7_dead  <= r6_dead;
            r7_depth <= r6_depth;
            r7_nx    <= r6_nx;
            r7_ny    <= r6_ny;
            r7_rfx   <= r6_rfx;
            r7_rfy   <= r6_rfy;
        end
    end

    // stage 8: face and side offset products
    logic signed [31:0] r8_rpx, r8_rpy, r8_ipx, r8_ipy;
    logic signed [48:0] r8_fpx, r8_fpy, r8_ifx, r8_ify;
    logic signed [48:0] r8_spx, r8_spy, r8_isx, r8_isy;
    logic signed [16:0] r8_rsx, r8_rsy;
    logic               r8_dead;
    logic        [38:0] r8_depth;
    logic signed [16:0] r8_nx, r8_ny, r8_rfx, r8_rfy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_rpx   <= r7_rpx;
            r8_rpy   <= r7_rpy;
            r8_ipx   <= r7_ipx;
            r8_ipy   <= r7_ipy;
            r8_fpx   <= 49'(r7_rdx) * 49'(r7_rlen);
            r8_fpy   <= 49'(r7_rdy) * 49'(r7_rlen);
            r8_ifx   <= 49'(r7_idx) * 49'(r7_ilen);
            r8_ify   <= 49'(r7_idy) * 49'(r7_ilen);
            r8_spx   <= 49'(r7_rsx) * 49'($signed({1'b0, r7_rsl}));
            r8_spy   <= 49'(r7_rsy) * 49'($signed({1'b0, r7_rsl}));
            r8_isx   <= 49'(r7_isx) * 49'($signed({1'b0, r7_isl}));
            r8_isy   <= 49'(r7_isy) * 49'($signed({1'b0, r7_isl}));
            r8_rsx   <= r7_rsx;
            r8_rsy   <= r7_rsy;
            r8_dead  <= r7_dead;
            r8_depth <= r7_depth;
            r8_nx    <= r7_nx;
            r8_ny    <= r7_ny;
            r8_rfx   <= r7_rfx;
            r8_rfy   <= r7_rfy;
        end
    end

    // stage 9: face centers and side offsets in both directions
    logic signed [31:0] r9_fcx, r9_fcy, r9_ifcx, r9_ifcy;
    logic signed [34:0] r9_rpx, r9_rpy, r9_rnx, r9_rny;
    logic signed [34:0] r9_ipx2, r9_ipy2, r9_inx, r9_iny;
    logic signed [16:0] r9_rsx, r9_rsy;
    logic               r9_dead;
    logic        [38:0] r9_depth;
    logic signed [16:0] r9_nx, r9_ny, r9_rfx, r9_rfy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r9_fcx   <= occ_pkg::sat32(40'(r8_rpx) + 40'(r8_fpx >>> DF));
            r9_fcy   <= occ_pkg::sat32(40'(r8_rpy) + 40'(r8_fpy >>> DF));
            r9_ifcx  <= occ_pkg::sat32(40'(r8_ipx) + 40'(r8_ifx >>> DF));
            r9_ifcy  <= occ_pkg::sat32(40'(r8_ipy) + 40'(r8_ify >>> DF));
            r9_rpx   <= 35'(r8_spx >>> DF);
            r9_rpy   <= 35'(r8_spy >>> DF);
            r9_rnx   <= 35'((-r8_spx) >>> DF);
            r9_rny   <= 35'((-r8_spy) >>> DF);
            r9_ipx2  <= 35'(r8_isx >>> DF);
            r9_ipy2  <= 35'(r8_isy >>> DF);
            r9_inx   <= 35'((-r8_isx) >>> DF);
            r9_iny   <= 35'((-r8_isy) >>> DF);
            r9_rsx   <= r8_rsx;
            r9_rsy   <= r8_rsy;
            r9_dead  <= r8_dead;
            r9_depth <= r8_depth;
            r9_nx    <= r8_nx;
            r9_ny    <= r8_ny;
            r9_rfx   <= r8_rfx;
            r9_rfy   <= r8_rfy;
        end
    end

    // stage 10: side plane points and incident edge ends
    occ_pkg::t_ctx r10_ctx;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_ctx.dead  <= r9_dead;
            r10_ctx.nx    <= r9_nx;
            r10_ctx.ny    <= r9_ny;
            r10_ctx.depth <= r9_depth;
            r10_ctx.rfx   <= r9_rfx;
            r10_ctx.rfy   <= r9_rfy;
            r10_ctx.fcx   <= r9_fcx;
            r10_ctx.fcy   <= r9_fcy;
            r10_ctx.rsx   <= occ_pkg::sat32(40'(r9_fcx) + 40'(r9_rpx));
            r10_ctx.rsy   <= occ_pkg::sat32(40'(r9_fcy) + 40'(r9_rpy));
            r10_ctx.rex   <= occ_pkg::sat32(40'(r9_fcx) + 40'(r9_rnx));
            r10_ctx.rey   <= occ_pkg::sat32(40'(r9_fcy) + 40'(r9_rny));
            r10_ctx.sdx   <= r9_rsx;
            r10_ctx.sdy   <= r9_rsy;
            r10_ctx.c0x   <= occ_pkg::sat32(40'(r9_ifcx) + 40'(r9_ipx2));
            r10_ctx.c0y   <= occ_pkg::sat32(40'(r9_ifcy) + 40'(r9_ipy2));
            r10_ctx.c1x   <= occ_pkg::sat32(40'(r9_ifcx) + 40'(r9_inx));
            r10_ctx.c1y   <= occ_pkg::sat32(40'(r9_ifcy) + 40'(r9_iny));
        end
    end

    // clip against the positive side plane, then the negative one
    occ_pkg::t_ctx w_c1_ctx, w_c2_ctx;

    occ_clip u_clip_pos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_vld[10]),
        .i_ctx   (r10_ctx),
        .i_ppx   (r10_ctx.rsx),
        .i_ppy   (r10_ctx.rsy),
        .i_pnx   (-r10_ctx.sdx),
        .i_pny   (-r10_ctx.sdy),
        .o_vld   (w_c1_vld),
        .o_ctx   (w_c1_ctx)
    );

    occ_clip u_clip_neg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (w_c1_vld),
        .i_ctx   (w_c1_ctx),
        .i_ppx   (w_c1_ctx.rex),
        .i_ppy   (w_c1_ctx.rey),
        .i_pnx   (w_c1_ctx.sdx),
        .i_pny   (w_c1_ctx.sdy),
        .o_vld   (w_c2_vld),
        .o_ctx   (w_c2_ctx)
    );

    // depth products against the reference plane
    occ_pkg::t_ctx      r_f1_ctx;
    logic signed [49:0] r_f1_m0x, r_f1_m0y, r_f1_m1x, r_f1_m1y;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_ctx <= w_c2_ctx;
            r_f1_m0x <= 50'(33'(w_c2_ctx.c0x) - 33'(w_c2_ctx.fcx)) * 50'(w_c2_ctx.rfx);
            r_f1_m0y <= 50'(33'(w_c2_ctx.c0y) - 33'(w_c2_ctx.fcy)) * 50'(w_c2_ctx.rfy);
            r_f1_m1x <= 50'(33'(w_c2_ctx.c1x) - 33'(w_c2_ctx.fcx)) * 50'(w_c2_ctx.rfx);
            r_f1_m1y <= 50'(33'(w_c2_ctx.c1y) - 33'(w_c2_ctx.fcy)) * 50'(w_c2_ctx.rfy);
        end
    end

    // tolerance test and result assembly
    logic signed [50:0] w_s0, w_s1;
    logic               w_k0, w_k1;
    occ_pkg::t_out      n_out;

    always_comb begin
        w_s0  = 51'(r_f1_m0x) + 51'(r_f1_m0y);
        w_s1  = 51'(r_f1_m1x) + 51'(r_f1_m1y);
        w_k0  = w_s0 <= 51'(occ_pkg::CONTACT_TOL);
        w_k1  = w_s1 <= 51'(occ_pkg::CONTACT_TOL);
        n_out = '0;
        if (!r_f1_ctx.dead && (w_k0 || w_k1)) begin
            n_out.contact_count = {1'b0, w_k0} + {1'b0, w_k1};
            n_out.normal_x      = r_f1_ctx.nx[15:0];
            n_out.normal_y      = r_f1_ctx.ny[15:0];
            n_out.penetration   = (r_f1_ctx.depth > 39'h7FFFFFFF) ? 31'h7FFFFFFF
                                                                  : r_f1_ctx.depth[30:0];
            n_out.point0_x      = w_k0 ? r_f1_ctx.c0x : r_f1_ctx.c1x;
            n_out.point0_y      = w_k0 ? r_f1_ctx.c0y : r_f1_ctx.c1y;
            if (w_k0 && w_k1) begin
                n_out.point1_x = r_f1_ctx.c1x;
                n_out.point1_y = r_f1_ctx.c1y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_out_data <= n_out;
        end
    end

endmodule

`default_nettype wire

[bench/occ_contact_checker.sv]
// ---------------------------------------------------------------------------
// occ_contact_checker: result predictor and scoreboard for the contact unit
// Watches both channels, computes the expected contact for every accepted
// box pair and compares each result transfer field by field, in order.
// ---------------------------------------------------------------------------
`default_nettype none

module occ_contact_checker (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_ready,
    input  wire occ_pkg::t_in  i_in_data,
    input  wire logic          i_out_valid,
    input  wire logic          i_out_ready,
    input  wire occ_pkg::t_out i_out_data,
    output int                 o_errors,
    output int                 o_pending
);

    localparam longint TOL   = 10737;
    localparam longint T_ONE = 65536;

    occ_pkg::t_out contacts_due[$];

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint labs(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // point moved along a Q2.14 direction by a Q16.16 length
    function automatic longint step_along(longint p, longint d, longint len);
        return clamp32(p + ((d * len) >>> 14));
    endfunction

    // face of a box facing n (or facing away from n)
    function automatic void face_of(
        input longint px, py, rx, ry, ux, uy, hw, hh, nx, ny,
        input bit away,
        output longint fx, fy, sx, sy, slen);
        longint dx, dy, h;
        bit use_x, negv;
        dx = nx * rx + ny * ry;
        dy = nx * ux + ny * uy;
        use_x = labs(dx) > labs(dy);
        negv = (use_x ? dx : dy) < 0;
        h = use_x ? hw : hh;
        if (away) negv = !negv;
        if (negv) h = -h;
        fx = step_along(px, use_x ? rx : ux, h);
        fy = step_along(py, use_x ? ry : uy, h);
        sx = use_x ? ux : rx;
        sy = use_x ? uy : ry;
        slen = use_x ? hh : hw;
    endfunction

    // clip segment against a side plane, returns 1 when fully outside
    function automatic bit cut_segment(
        inout longint x1, y1, x2, y2,
        input longint qx, qy, nx, ny);
        longint d1, d2, den, t, hx, hy;
        d1 = ((x1 - qx) * nx + (y1 - qy) * ny) >>> 14;
        d2 = ((x2 - qx) * nx + (y2 - qy) * ny) >>> 14;
        if (d1 >= 0 && d2 >= 0) return 0;
        if (d1 < 0 && d2 < 0) return 1;
        den = d1 - d2;
        t = (den != 0) ? (d1 * T_ONE) / den : 0;
        if (t < 0) t = 0;
        if (t > T_ONE) t = T_ONE;
        hx = clamp32(x1 + (((x2 - x1) * t) >>> 16));
        hy = clamp32(y1 + (((y2 - y1) * t) >>> 16));
        if (d1 >= 0) begin
            x2 = hx; y2 = hy;
        end else begin
            x1 = hx; y1 = hy;
        end
        return 0;
    endfunction

    function automatic occ_pkg::t_out contact_of(occ_pkg::t_in p);
        longint pax, pay, pbx, pby, ca, sa, cb, sb, hwa, hha, hwb, hhb;
        longint rc, rsn, ddx, ddy, ov, depth, nx, ny, rnx, rny, plane;
        longint ax[4], ay[4], sums[4], proj;
        longint fx, fy, sx, sy, slen, ix, iy, isx, isy, islen;
        longint rsx, rsy, rex, rey, cx[2], cy[2], px[2], py[2];
        int best, cnt;
        occ_pkg::t_out r;
        r = '0;
        pax = longint'(p.a_center_x); pay = longint'(p.a_center_y);
        pbx = longint'(p.b_center_x); pby = longint'(p.b_center_y);
        ca = longint'(p.a_cos); sa = longint'(p.a_sin);
        cb = longint'(p.b_cos); sb = longint'(p.b_sin);
        hwa = longint'({1'b0, p.a_half_width}); hha = longint'({1'b0, p.a_half_height});
        hwb = longint'({1'b0, p.b_half_width}); hhb = longint'({1'b0, p.b_half_height});
        rc  = labs((ca * cb + sa * sb) >>> 14);
        rsn = labs((ca * sb - sa * cb) >>> 14);
        ddx = pbx - pax; ddy = pby - pay;
        ax[0] = ca; ay[0] = sa; ax[1] = -sa; ay[1] = ca;
        ax[2] = cb; ay[2] = sb; ax[3] = -sb; ay[3] = cb;
        sums[0] = ((hwb * rc) >>> 14) + ((hhb * rsn) >>> 14) + hwa;
        sums[1] = ((hwb * rsn) >>> 14) + ((hhb * rc) >>> 14) + hha;
        sums[2] = ((hwa * rc) >>> 14) + ((hha * rsn) >>> 14) + hwb;
        sums[3] = ((hwa * rsn) >>> 14) + ((hha * rc) >>> 14) + hhb;
        best = 0; depth = 0; nx = 0; ny = 0;
        // separating-axis tests, earliest axis wins ties
        for (int i = 0; i < 4; i++) begin
            proj = (ddx * ax[i] + ddy * ay[i]) >>> 14;
            ov = sums[i] - labs(proj);
            if (ov < 0) return r;
            if (i == 0 || ov < depth) begin
                depth = ov;
                best = i;
                nx = (proj < 0) ? -ax[i] : ax[i];
                ny = (proj < 0) ? -ay[i] : ay[i];
            end
        end
        // reference face on the box owning the best axis
        if (best < 2) begin
            rnx = nx; rny = ny;
            face_of(pax, pay, ca, sa, -sa, ca, hwa, hha, rnx, rny, 0, fx, fy, sx, sy, slen);
            face_of(pbx, pby, cb, sb, -sb, cb, hwb, hhb, rnx, rny, 1,
                    ix, iy, isx, isy, islen);
        end else begin
            rnx = -nx; rny = -ny;
            face_of(pbx, pby, cb, sb, -sb, cb, hwb, hhb, rnx, rny, 0, fx, fy, sx, sy, slen);
            face_of(pax, pay, ca, sa, -sa, ca, hwa, hha, rnx, rny, 1,
                    ix, iy, isx, isy, islen);
        end
        rsx = step_along(fx, sx, slen);  rsy = step_along(fy, sy, slen);
        rex = step_along(fx, sx, -slen); rey = step_along(fy, sy, -slen);
        cx[0] = step_along(ix, isx, islen);  cy[0] = step_along(iy, isy, islen);
        cx[1] = step_along(ix, isx, -islen); cy[1] = step_along(iy, isy, -islen);
        if (cut_segment(cx[0], cy[0], cx[1], cy[1], rsx, rsy, -sx, -sy)) return r;
        if (cut_segment(cx[0], cy[0], cx[1], cy[1], rex, rey, sx, sy)) return r;
        // keep points within tolerance of the reference plane
        plane = fx * rnx + fy * rny;
        cnt = 0;
        px[0] = 0; py[0] = 0; px[1] = 0; py[1] = 0;
        for (int i = 0; i < 2; i++) begin
            if (cx[i] * rnx + cy[i] * rny - plane <= TOL) begin
                px[cnt] = cx[i]; py[cnt] = cy[i];
                cnt++;
            end
        end
        if (cnt == 0) return r;
        if (depth > 64'sd2147483647) depth = 64'sd2147483647;
        r.contact_count = cnt[1:0];
        r.normal_x = nx[15:0];
        r.normal_y = ny[15:0];
        r.penetration = depth[30:0];
        r.point0_x = px[0][31:0];
        r.point0_y = py[0][31:0];
        r.point1_x = px[1][31:0];
        r.point1_y = py[1][31:0];
        return r;
    endfunction

    function automatic int field_bad(string name, longint e, longint a);
        if (e != a) begin
            $display("%0t: mismatch %s expected %0d actual %0d", $time, name, e, a);
            return 1;
        end
        return 0;
    endfunction

    assign o_pending = contacts_due.size();

    // predict on input transfer, compare on output transfer
    always @(posedge i_clk) begin
        occ_pkg::t_out e;
        int bad;
        if (!i_rst_n) begin
            o_errors <= 0;
        end else begin
            if (i_in_valid && i_in_ready) contacts_due.push_back(contact_of(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (contacts_due.size() == 0) begin
                    $display("%0t: unexpected result transfer", $time);
                    o_errors <= o_errors + 1;
                end else begin
                    e = contacts_due.pop_front();
                    bad = field_bad("contact_count", e.contact_count, i_out_data.contact_count)
                        + field_bad("normal_x", e.normal_x, i_out_data.normal_x)
                        + field_bad("normal_y", e.normal_y, i_out_data.normal_y)
                        + field_bad("penetration", e.penetration, i_out_data.penetration)
                        + field_bad("point0_x", e.point0_x, i_out_data.point0_x)
                        + field_bad("point0_y", e.point0_y, i_out_data.point0_y)
                        + field_bad("point1_x", e.point1_x, i_out_data.point1_x)
                        + field_bad("point1_y", e.point1_y, i_out_data.point1_y);
                    if (bad != 0) o_errors <= o_errors + 1;
                end
            end
        end
    end

endmodule

`default_nettype wire

[bench/tb_obb_obb_contact_clipping_unit.sv]
// ---------------------------------------------------------------------------
// tb_obb_obb_contact_clipping_unit: stimulus and verdict for the contact unit
// Drives directed box pairs, then random overlapping and noise pairs with
// random gaps and output stalls; the checker predicts and compares.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_obb_obb_contact_clipping_unit;

    localparam int N_RANDOM   = 1400;
    localparam int IDLE_LIMIT = 20000;
    localparam real PI = 3.14159265358979;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    occ_pkg::t_in  in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    occ_pkg::t_out out_data;
    int   errors, pending;
    logic in_xfer_q = 1'b0;
    int   idle_cycles = 0;
    int   stall_left = 0;
    bit   no_stalls = 0;
    bit   no_gaps = 0;

    always #5 i_clk = ~i_clk;

    obb_obb_contact_clipping_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data)
    );

    occ_contact_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .o_errors(errors), .o_pending(pending)
    );

    // input transfer flag and idle watchdog
    always @(posedge i_clk) begin
        in_xfer_q <= in_valid && in_ready;
        if ((in_valid && in_ready) || (out_valid && out_ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // receiver stalls, mostly short, a few long
    always @(negedge i_clk) begin
        if (!i_rst_n || no_stalls) begin
            out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ready <= 1'b0;
        end else if ($urandom_range(0, 99) < 25) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                      : $urandom_range(0, 3);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    function automatic int gap_len();
        if (no_gaps || $urandom_range(0, 99) < 60) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 50);
        return $urandom_range(1, 3);
    endfunction

    // one pair transfer; valid stays high across back-to-back items
    task automatic send_pair(occ_pkg::t_in p);
        int gap;
        in_data = p;
        in_valid = 1'b1;
        do @(negedge i_clk); while (!in_xfer_q);
        gap = gap_len();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    function automatic occ_pkg::t_in pair_of(longint ax, ay, int ac, as, longint aw, ah,
                                             longint bx, by, int bc, bs, longint bw, bh);
        occ_pkg::t_in p;
        p.a_center_x = ax[31:0]; p.a_center_y = ay[31:0];
        p.a_cos = ac[15:0]; p.a_sin = as[15:0];
        p.a_half_width = aw[30:0]; p.a_half_height = ah[30:0];
        p.b_center_x = bx[31:0]; p.b_center_y = by[31:0];
        p.b_cos = bc[15:0]; p.b_sin = bs[15:0];
        p.b_half_width = bw[30:0]; p.b_half_height = bh[30:0];
        return p;
    endfunction

    function automatic int rot_q14(real a, bit sine);
        return $rtoi($floor(16384.0 * (sine ? $sin(a) : $cos(a)) + 0.5));
    endfunction

    function automatic longint clamp(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // well-formed overlapping pair with random rotation and size
    function automatic occ_pkg::t_in random_pair();
        longint base_x, base_y, aw, ah, bw, bh, reach;
        real a1, a2;
        int c1, s1, c2, s2;
        a1 = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) * PI / 2.0
                                         : $urandom_range(0, 3599) * PI / 1800.0;
        a2 = ($urandom_range(0, 3) == 0) ? a1 : $urandom_range(0, 3599) * PI / 1800.0;
        c1 = rot_q14(a1, 0); s1 = rot_q14(a1, 1);
        c2 = rot_q14(a2, 0); s2 = rot_q14(a2, 1);
        if ($urandom_range(0, 9) == 0) begin
            aw = $urandom_range(1, 32'h7FFF_FFFF); ah = $urandom_range(1, 32'h7FFF_FFFF);
            bw = $urandom_range(1, 32'h7FFF_FFFF); bh = $urandom_range(1, 32'h7FFF_FFFF);
        end else begin
            aw = $urandom_range(1, 5 << 16); ah = $urandom_range(1, 5 << 16);
            bw = $urandom_range(1, 5 << 16); bh = $urandom_range(1, 5 << 16);
        end
        if ($urandom_range(0, 9) == 0) begin
            base_x = longint'($signed($urandom()));
            base_y = longint'($signed($urandom()));
        end else begin
            base_x = longint'($urandom_range(0, 1 << 24)) - (1 << 23);
            base_y = longint'($urandom_range(0, 1 << 24)) - (1 << 23);
        end
        reach = aw + ah + bw + bh;
        if (reach > 32'h7FFF_FFFF) reach = 32'h7FFF_FFFF;
        return pair_of(base_x, base_y, c1, s1, aw, ah,
                       clamp(base_x + longint'($urandom_range(0, 32'(reach))) - reach / 2),
                       clamp(base_y + longint'($urandom_range(0, 32'(reach))) - reach / 2),
                       c2, s2, bw, bh);
    endfunction

    function automatic occ_pkg::t_in noise_pair();
        occ_pkg::t_in p;
        p = $bits(occ_pkg::t_in)'({$urandom(), $urandom(), $urandom(), $urandom(),
                                   $urandom(), $urandom(), $urandom(), $urandom(),
                                   $urandom(), $urandom()});
        p.a_cos = 16'($signed($urandom_range(0, 32768)) - 16384);
        p.a_sin = 16'($signed($urandom_range(0, 32768)) - 16384);
        p.b_cos = 16'($signed($urandom_range(0, 32768)) - 16384);
        p.b_sin = 16'($signed($urandom_range(0, 32768)) - 16384);
        return p;
    endfunction

    task automatic drain();
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        longint one, hmax, cmax, cmin;
        one = 1 << 16;
        hmax = 32'h7FFF_FFFF;
        cmax = 32'sh7FFF_FFFF;
        cmin = -64'sd2147483648;
        no_gaps = 1;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: overlaps, separations per axis, ties, rotations, extremes
        send_pair(pair_of(0, 0, 16384, 0, one, one, one, 0, 16384, 0, one, one));
        send_pair(pair_of(0, 0, 16384, 0, one, one, 0, one, 16384, 0, one, one));
        send_pair(pair_of(0, 0, 16384, 0, one, one, 0, 0, 16384, 0, one, one));
        send_pair(pair_of(0, 0, 16384, 0, one, one, 3 * one, 0, 16384, 0, one, one));
        send_pair(pair_of(0, 0, 16384, 0, one, one, 0, -3 * one, 16384, 0, one, one));
        send_pair(pair_of(0, 0, 16384, 0, one, one, 2 * one, 0, 16384, 0, one, one));
        send_pair(pair_of(0, 0, 16384, 0, one, one, one, one, 11585, 11585, one, one));
        send_pair(pair_of(0, 0, 11585, 11585, 4 * one, one, 3 * one, 3 * one,
                          16384, 0, one, one));
        send_pair(pair_of(0, 0, 11585, -11585, 4 * one, one, -3 * one, 2 * one,
                          -16384, 0, one, 2 * one));
        send_pair(pair_of(0, 0, 0, 16384, 2 * one, one, -one, -one, 0, -16384, one, one));
        send_pair(pair_of(0, 0, -16384, 0, one, one, -one, 0, 0, 16384, one, 3 * one));
        send_pair(pair_of(0, 0, 16384, 0, 0, 0, 0, 0, 16384, 0, 0, 0));
        send_pair(pair_of(0, 0, 16384, 0, one, one, 0, one / 2, 16384, 0, 8 * one, one));
        send_pair(pair_of(cmax, cmax, 16384, 0, hmax, hmax, cmin, cmin, 16384, 0, hmax, hmax));
        send_pair(pair_of(cmin, cmax, 11585, 11585, hmax, hmax, cmax, cmin,
                          -11585, 11585, hmax, hmax));
        send_pair(pair_of(cmax, cmax, 16384, 0, hmax, 1, cmax, cmax, 0, 16384, 1, hmax));
        send_pair(pair_of(cmin, cmin, -16384, 0, one, one, cmin + one, cmin, 0, -16384,
                          one, one));
        send_pair(pair_of(0, 0, -16384, -16384, hmax, hmax, 5, -5, 16384, 16384, 1, 1));
        send_pair(pair_of(0, 0, 16384, 0, one, one, one, one, 16384, 0, one, one));
        send_pair(pair_of(0, 0, 16384, 0, one, one, -2 * one, 0, 16384, 0, one, one));
        no_gaps = 0;

        // random: mostly overlapping pairs, some raw noise
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM / 3) no_stalls = 1;
            if (n == N_RANDOM / 2) begin
                no_stalls = 0;
                in_valid = 1'b0;
                drain();
            end
            if (n == 2 * N_RANDOM / 3) no_gaps = 1;
            if (n == 5 * N_RANDOM / 6) no_gaps = 0;
            send_pair(($urandom_range(0, 9) == 0) ? noise_pair() : random_pair());
        end
        in_valid = 1'b0;
        drain();
        repeat (60) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
